// ===== rtl/core/lcasr_pkg.sv =====
`timescale 1ns / 1ps

package lcasr_pkg;

	localparam int DATA_BITS        = 24;
	localparam int SAMPLES_AVERAGED = 10;

	localparam int TARE_W     = 24;
	localparam int SCALE_W    = 24;
	localparam int WEIGHT_W   = 26;
	localparam int FRAC_SHIFT = 16;

	localparam int SUM_W    = DATA_BITS + $clog2(SAMPLES_AVERAGED);
	localparam int WORDS_W  = $clog2(SAMPLES_AVERAGED + 1);
	localparam int PIDX_W   = $clog2(DATA_BITS + 2);
	localparam int REM_W    = $clog2(SAMPLES_AVERAGED + 1);
	localparam int DIFF_W   = TARE_W + 1;
	localparam int TOP_W    = DIFF_W + 1 + SCALE_W - FRAC_SHIFT;
	localparam int ITER_MAX = (SUM_W > SCALE_W) ? SUM_W : SCALE_W;
	localparam int CNT_W    = $clog2(ITER_MAX);

	localparam int W_MAX = 2 ** (WEIGHT_W - 1) - 1;
	localparam int W_MIN = -(2 ** (WEIGHT_W - 1));

	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = ((1 + WEIGHT_W + 7) / 8) * 8;

	localparam logic [0:0] REG_TARE  = 1'b0;
	localparam logic [0:0] REG_SCALE = 1'b1;

	localparam logic signed [TARE_W-1:0] TARE_RESET  = '0;
	localparam logic [SCALE_W-1:0]       SCALE_RESET = SCALE_W'(79476);

	typedef struct packed {
		logic                       valid;
		logic signed [WEIGHT_W-1:0] weight;
	} lcasr_res_t;

endpackage

// ===== rtl/core/lcasr_calc.sv =====
`timescale 1ns / 1ps

module lcasr_calc
	import lcasr_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [SUM_W-1:0]  sum,
	input  logic signed [TARE_W-1:0] tare,
	input  logic [SCALE_W-1:0]       scale,
	input  logic                     take,
	output lcasr_res_t               res
);

	localparam logic [2:0] C_IDLE = 3'd0;
	localparam logic [2:0] C_DIV  = 3'd1;
	localparam logic [2:0] C_AVG  = 3'd2;
	localparam logic [2:0] C_MUL  = 3'd3;
	localparam logic [2:0] C_SAT  = 3'd4;
	localparam logic [2:0] C_DONE = 3'd5;

	logic [2:0]                 st_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       neg_q;
	logic [SUM_W-1:0]           dvd_q;
	logic [REM_W-1:0]           rem_q;
	logic signed [DIFF_W-1:0]   diff_q;
	logic signed [DIFF_W:0]     hi_q;
	logic [SCALE_W-1:0]         lo_q;
	logic signed [WEIGHT_W-1:0] wt_q;

	logic [REM_W:0]             trial;
	logic                       ge;
	logic [REM_W-1:0]           rem_nx;
	logic signed [DIFF_W-1:0]   quo;
	logic signed [DIFF_W-1:0]   avg;
	logic signed [DIFF_W+1:0]   mul_sum;
	logic signed [TOP_W-1:0]    prod_top;
	logic signed [WEIGHT_W-1:0] sat;

	// one quotient bit per cycle, remainder stays below the divisor
	assign trial  = {rem_q, dvd_q[SUM_W-1]};
	assign ge     = trial >= (REM_W + 1)'(SAMPLES_AVERAGED);
	assign rem_nx = ge ? REM_W'(trial - (REM_W + 1)'(SAMPLES_AVERAGED)) : REM_W'(trial);

	assign quo = signed'(DIFF_W'(dvd_q));
	assign avg = neg_q ? -quo : quo;

	// signed multiplicand, multiplier bits taken lsb first
	assign mul_sum = {hi_q[DIFF_W], hi_q} +
		(lo_q[0] ? {diff_q[DIFF_W-1], diff_q[DIFF_W-1], diff_q} : '0);

	assign prod_top = {hi_q, lo_q[SCALE_W-1:FRAC_SHIFT]};

	always_comb begin
		if (prod_top > signed'(TOP_W'(W_MAX))) begin
			sat = signed'(WEIGHT_W'(W_MAX));
		end else if (prod_top < signed'(TOP_W'(W_MIN))) begin
			sat = signed'(WEIGHT_W'(W_MIN));
		end else begin
			sat = signed'(WEIGHT_W'(prod_top));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= C_IDLE;
			cnt_q <= '0;
		end else begin
			case (st_q)
				C_IDLE: begin
					cnt_q <= '0;
					if (start) begin
						st_q <= C_DIV;
					end
				end
				C_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(SUM_W - 1)) begin
						st_q <= C_AVG;
					end
				end
				C_AVG: begin
					cnt_q <= '0;
					st_q  <= C_MUL;
				end
				C_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(SCALE_W - 1)) begin
						st_q <= C_SAT;
					end
				end
				C_SAT: begin
					st_q <= C_DONE;
				end
				C_DONE: begin
					if (take) begin
						st_q <= C_IDLE;
					end
				end
				default: begin
					st_q <= C_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			C_IDLE: begin
				neg_q <= sum[SUM_W-1];
				dvd_q <= sum[SUM_W-1] ? unsigned'(-sum) : unsigned'(sum);
				rem_q <= '0;
			end
			C_DIV: begin
				dvd_q <= {dvd_q[SUM_W-2:0], ge};
				rem_q <= rem_nx;
			end
			C_AVG: begin
				diff_q <= avg - DIFF_W'(tare);
				hi_q   <= '0;
				lo_q   <= scale;
			end
			C_MUL: begin
				hi_q <= mul_sum[DIFF_W+1:1];
				lo_q <= {mul_sum[0], lo_q[SCALE_W-1:1]};
			end
			C_SAT: begin
				wt_q <= sat;
			end
			default: begin
			end
		endcase
	end

	assign res.valid  = (st_q == C_DONE);
	assign res.weight = wt_q;

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> st_q == C_IDLE)
		else $error("start while busy");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == C_DIV |-> rem_q < REM_W'(SAMPLES_AVERAGED))
		else $error("remainder out of range");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == C_DONE && !take) |=> st_q == C_DONE && $stable(wt_q))
		else $error("result dropped");
`endif

endmodule

// ===== rtl/core/load_cell_adc_serial_reader_top.sv =====
// one tick per cycle unless busy or the output stalls; a taken tick is registered
// the tick that closes the last averaged word waits for the weight unit, which
// runs a bit-serial divide by the sample count and then a shift-add multiply;
// no tick is taken meanwhile
// arst_n clears the bus state, the sum and count, and loads the register defaults
`timescale 1ns / 1ps

module load_cell_adc_serial_reader_top
	import lcasr_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [IN_TDATA_W-1:0]    s_axis_tdata,  // dout

	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic [OUT_TDATA_W-1:0]   m_axis_tdata,  // sck, weight
	output logic                     m_axis_tuser,  // weight_valid

	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [0:0]               cfg_index,
	input  logic [31:0]              cfg_data
);

	localparam logic [1:0] PH_WAIT = 2'd0;
	localparam logic [1:0] PH_HIGH = 2'd1;
	localparam logic [1:0] PH_LOW  = 2'd2;

	logic signed [TARE_W-1:0] tare_q;
	logic [SCALE_W-1:0]       scale_q;

	logic [1:0]               phase_q, phase_nx;
	logic [PIDX_W-1:0]        pidx_q, pidx_nx;
	logic [DATA_BITS-1:0]     shift_q, shift_nx;
	logic signed [SUM_W-1:0]  sum_q, sum_nx, sum_add;
	logic [WORDS_W-1:0]       words_q, words_nx;
	logic                     busy_q;

	logic                     ovalid_q;
	logic [OUT_TDATA_W-1:0]   odata_q;
	logic                     ouser_q;

	logic                     din;
	logic                     sck;
	logic                     fire;
	logic                     s_accept;
	logic                     out_free;
	logic                     ld_tick;
	logic                     ld_res;
	lcasr_res_t               res;

	assign din      = s_axis_tdata[0];
	assign out_free = !ovalid_q || m_axis_tready;
	assign s_axis_tready = !busy_q && out_free;
	assign s_accept = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	assign sum_add = sum_q + SUM_W'(signed'(shift_q));

	always_comb begin
		phase_nx = phase_q;
		pidx_nx  = pidx_q;
		shift_nx = shift_q;
		sum_nx   = sum_q;
		words_nx = words_q;
		sck      = 1'b0;
		fire     = 1'b0;
		case (phase_q)
			PH_HIGH: begin
				sck      = 1'b1;
				phase_nx = PH_LOW;
			end
			PH_LOW: begin
				if (pidx_q < PIDX_W'(DATA_BITS)) begin
					shift_nx = {shift_q[DATA_BITS-2:0], din};
				end
				pidx_nx = pidx_q + 1'b1;
				if (pidx_q == PIDX_W'(DATA_BITS)) begin
					sum_nx   = sum_add;
					words_nx = words_q + 1'b1;
					if (words_q == WORDS_W'(SAMPLES_AVERAGED - 1)) begin
						fire     = 1'b1;
						sum_nx   = '0;
						words_nx = '0;
					end
					shift_nx = '0;
					pidx_nx  = '0;
					phase_nx = PH_WAIT;
				end else begin
					phase_nx = PH_HIGH;
				end
			end
			default: begin
				phase_nx = din ? PH_WAIT : PH_HIGH;
				pidx_nx  = '0;
				shift_nx = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tare_q  <= TARE_RESET;
			scale_q <= SCALE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TARE:  tare_q  <= signed'(cfg_data[TARE_W-1:0]);
				REG_SCALE: scale_q <= cfg_data[SCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			pidx_q  <= '0;
			shift_q <= '0;
			sum_q   <= '0;
			words_q <= '0;
		end else if (s_accept) begin
			phase_q <= phase_nx;
			pidx_q  <= pidx_nx;
			shift_q <= shift_nx;
			sum_q   <= sum_nx;
			words_q <= words_nx;
		end
	end

	assign ld_tick = s_accept && !fire;
	assign ld_res  = res.valid && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (s_accept && fire) begin
				busy_q <= 1'b1;
			end else if (ld_res) begin
				busy_q <= 1'b0;
			end
			if (ld_tick || ld_res) begin
				ovalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_res) begin
			odata_q <= OUT_TDATA_W'({res.weight, 1'b0});
			ouser_q <= 1'b1;
		end else if (ld_tick) begin
			odata_q <= OUT_TDATA_W'({{WEIGHT_W{1'b0}}, sck});
			ouser_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = odata_q;
	assign m_axis_tuser  = ouser_q;

	lcasr_calc u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (s_accept && fire),
		.sum    (sum_add),
		.tare   (tare_q),
		.scale  (scale_q),
		.take   (ld_res),
		.res    (res)
	);

`ifndef SYNTHESIS
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> busy_q)
		else $error("weight ready without a pending word");

	a_fire_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && fire) |=> busy_q && !s_axis_tready)
		else $error("tick taken during weight computation");

	a_pidx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pidx_q <= PIDX_W'(DATA_BITS))
		else $error("pulse index out of range");

	a_wait_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_WAIT |-> pidx_q == '0 && shift_q == '0)
		else $error("stale word while waiting");

	a_words_bound: assert property (@(posedge clk) disable iff (!arst_n)
		words_q < WORDS_W'(SAMPLES_AVERAGED))
		else $error("word count out of range");
`endif

endmodule
